[sv/pressure_key_detector_calibrated_unit_defines.svh]
// Assertion macros shared by the key detector RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PRESSURE_KEY_DETECTOR_CALIBRATED_UNIT_DEFINES_SVH
`define PRESSURE_KEY_DETECTOR_CALIBRATED_UNIT_DEFINES_SVH

// cond implies prop in the same cycle
`define PKDC_ASSERT_SAME(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// cond implies prop in the next cycle
`define PKDC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

[sv/pkdc_pkg.sv]
// Shared types, widths and codes of the pressure key detector.
// No dependencies; imported by every module of the block.
`default_nettype none

package pkdc_pkg;

   localparam int SENSORS      = 5;
   localparam int SAMPLE_WIDTH = 12;

   localparam int OP_W           = 2;
   localparam int SENSOR_W       = 3;
   localparam int SAMPLE_FIELD_W = 12;
   localparam int EVENT_W        = 2;
   localparam int VEL_W          = 7;
   localparam int THR_W          = 12;
   localparam int CNT_W          = 10;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 12;

   localparam int SIDX_W  = (SENSORS > 1) ? $clog2(SENSORS) : 1;
   localparam int BASE_W  = SAMPLE_WIDTH + 2;
   localparam int PMAX_W  = SAMPLE_WIDTH + 1;
   localparam int SUM_W   = SAMPLE_WIDTH + 10;
   localparam int SQ_W    = 2 * SAMPLE_WIDTH + 10;
   localparam int ROOT_W  = SQ_W / 2;
   localparam int PROD_W  = SQ_W + CNT_W;
   localparam int NN_W    = 2 * CNT_W;
   localparam int NUM_W   = SAMPLE_WIDTH + 7;
   localparam int DIVD_W  = PROD_W;
   localparam int DIVS_W  = NN_W;
   localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);
   localparam int SQRT_CNT_W = $clog2(ROOT_W + 1);

   localparam logic [THR_W-1:0] RST_PRESS_THR = THR_W'(45);
   localparam logic [THR_W-1:0] RST_REL_THR   = THR_W'(25);
   localparam logic [CNT_W-1:0] RST_COUNT     = CNT_W'(150);
   localparam logic [VEL_W-1:0] VEL_MAX       = VEL_W'(127);
   localparam int               VEL_GAIN      = 126;

   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_THR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REL_THR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT     = 2'd2;

   localparam logic [OP_W-1:0] OP_OPEN   = 2'd0;
   localparam logic [OP_W-1:0] OP_HARD   = 2'd1;
   localparam logic [OP_W-1:0] OP_FINISH = 2'd2;
   localparam logic [OP_W-1:0] OP_RUN    = 2'd3;

   localparam logic [EVENT_W-1:0] EV_PRESS    = 2'd0;
   localparam logic [EVENT_W-1:0] EV_RELEASE  = 2'd1;
   localparam logic [EVENT_W-1:0] EV_CAL_OK   = 2'd2;
   localparam logic [EVENT_W-1:0] EV_CAL_FAIL = 2'd3;

   // divider operand selection
   localparam logic [1:0] DIV_VAR  = 2'd0;
   localparam logic [1:0] DIV_MEAN = 2'd1;
   localparam logic [1:0] DIV_VEL  = 2'd2;

   // result kinds staged by the datapath
   localparam logic [1:0] RES_PRESS   = 2'd0;
   localparam logic [1:0] RES_RELEASE = 2'd1;
   localparam logic [1:0] RES_CAL     = 2'd2;

   // velocity cases by the sign of press maximum minus baseline
   localparam logic [1:0] VM_GT = 2'd0;
   localparam logic [1:0] VM_LT = 2'd1;
   localparam logic [1:0] VM_EQ = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic [SENSOR_W-1:0]       sensor;
      logic [SAMPLE_FIELD_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [EVENT_W-1:0]  event_res;
      logic [SENSOR_W-1:0] event_sensor;
      logic [VEL_W-1:0]    velocity;
   } rsp_type;

   typedef struct packed {
      logic              load_item;
      logic              accum;
      logic              run_eval;
      logic              cal_init;
      logic              cal_mul;
      logic              cal_diff;
      logic              div_start;
      logic [1:0]        div_sel;
      logic              sqrt_start;
      logic              cal_write;
      logic              cal_hard;
      logic [SIDX_W-1:0] cal_idx;
      logic              set_res;
      logic [1:0]        res_sel;
      logic              rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            sensor_ok;
      logic            press_hit;
      logic            rel_hit;
      logic            vel_div;
      logic            div_busy;
      logic            sqrt_busy;
      logic            rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

[sv/pkdc_div.sv]
// Restoring divider, one quotient bit per cycle.
// Uses pkdc_pkg for operand widths.
`default_nettype none

module pkdc_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [pkdc_pkg::DIVD_W-1:0]     dividend,
   input  logic [pkdc_pkg::DIVS_W-1:0]     divisor,
   input  logic [pkdc_pkg::DIV_CNT_W-1:0]  steps,
   output logic                            busy,
   output logic [pkdc_pkg::DIVD_W-1:0]     quotient
);
   import pkdc_pkg::*;

   logic [DIVS_W:0]    rem_ff;
   logic [DIVD_W-1:0]  quo_ff;
   logic [DIVS_W-1:0]  den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic               busy_ff;
   logic [DIVS_W:0]    rem_sh;
   logic [DIVS_W:0]    rem_sub;
   logic               fits;

   // dividend is left aligned, so only the top 'steps' bits are worked
   assign rem_sh  = {rem_ff[DIVS_W-1:0], quo_ff[DIVD_W-1]};
   assign fits    = rem_sh >= {1'b0, den_ff};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= steps;
         rem_ff  <= '0;
         quo_ff  <= dividend;
         den_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? rem_sub : rem_sh;
         quo_ff <= {quo_ff[DIVD_W-2:0], fits};
         cnt_ff <= cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[sv/pkdc_sqrt.sv]
// Integer square root, one result bit per cycle (digit by digit).
// Uses pkdc_pkg for the operand width.
`default_nettype none

module pkdc_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pkdc_pkg::SQ_W-1:0]     value,
   output logic                          busy,
   output logic [pkdc_pkg::ROOT_W-1:0]   root
);
   import pkdc_pkg::*;

   logic [SQ_W-1:0]       val_ff;
   logic [ROOT_W+1:0]     rem_ff;
   logic [ROOT_W-1:0]     root_ff;
   logic [SQRT_CNT_W-1:0] cnt_ff;
   logic                  busy_ff;
   logic [ROOT_W+3:0]     rem_sh;
   logic [ROOT_W+3:0]     trial;
   logic                  fits;
   logic [ROOT_W+3:0]     rem_sub;

   assign rem_sh  = {rem_ff, val_ff[SQ_W-1 -: 2]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign fits    = rem_sh >= trial;
   assign rem_sub = rem_sh - trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= SQRT_CNT_W'(ROOT_W);
         val_ff  <= value;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         val_ff  <= {val_ff[SQ_W-3:0], 2'b00};
         rem_ff  <= fits ? rem_sub[ROOT_W+1:0] : rem_sh[ROOT_W+1:0];
         root_ff <= {root_ff[ROOT_W-2:0], fits};
         cnt_ff  <= cnt_ff - SQRT_CNT_W'(1);
         if (cnt_ff == SQRT_CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

[sv/pkdc_datapath.sv]
// Datapath: config registers, per-sensor stores, run detector, output register.
// Uses pkdc_pkg, pkdc_div and pkdc_sqrt; driven by pkdc_ctrl commands.
`default_nettype none

module pkdc_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [pkdc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pkdc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  pkdc_pkg::req_type                  req_payload,
   input  pkdc_pkg::dp_cmd_type               cmd,
   output pkdc_pkg::dp_status_type            status,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output pkdc_pkg::rsp_type                  rsp_payload
);
   import pkdc_pkg::*;

   localparam int RC_W = ((BASE_W > THR_W) ? BASE_W : THR_W) + 1;
   localparam logic [SUM_W:0] BASE_SAT = (SUM_W+1)'((64'd1 << BASE_W) - 64'd1);
   localparam logic [SUM_W:0] PMAX_SAT = (SUM_W+1)'((64'd1 << PMAX_W) - 64'd1);

   logic [THR_W-1:0] press_thr_ff, rel_thr_ff;
   logic [CNT_W-1:0] count_ff;
   req_type          item_ff;

   logic [SUM_W-1:0]  open_sum_ff [SENSORS];
   logic [SUM_W-1:0]  hard_sum_ff [SENSORS];
   logic [SQ_W-1:0]   open_sq_ff  [SENSORS];
   logic [SQ_W-1:0]   hard_sq_ff  [SENSORS];
   logic [BASE_W-1:0] base_ff     [SENSORS];
   logic [PMAX_W-1:0] pmax_ff     [SENSORS];
   logic [SENSORS-1:0] pressed_ff;

   logic [PROD_W-1:0] prod_a_ff, prod_b_ff, diff_ff;
   logic [NN_W-1:0]   nn_ff;
   logic [BASE_W-1:0] btmp_ff;
   logic              fail_ff;
   logic [SIDX_W-1:0] fail_idx_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [1:0]        vmode_ff;
   rsp_type           res_ff;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;

   logic [SAMPLE_WIDTH-1:0]   s;
   logic [2*SAMPLE_WIDTH-1:0] s_sq;
   logic [CNT_W-1:0]  n_eff;
   logic [SIDX_W-1:0] idx;
   logic [SUM_W-1:0]  sel_sum;
   logic [SQ_W-1:0]   sel_sq;
   logic [BASE_W-1:0] base;
   logic [PMAX_W-1:0] pmax;
   logic [BASE_W-1:0] pmax_x;
   logic [RC_W-1:0]   press_lvl, rel_lvl, s_x;
   logic              press_hit, rel_hit;
   logic [SAMPLE_WIDTH-1:0] run_d;

   logic                 div_start;
   logic [DIVD_W-1:0]    div_dividend;
   logic [DIVS_W-1:0]    div_divisor;
   logic [DIV_CNT_W-1:0] div_steps;
   logic                 div_busy;
   logic [DIVD_W-1:0]    div_q;
   logic                 sqrt_busy;
   logic [ROOT_W-1:0]    sd;

   logic [SUM_W-1:0]  mean;
   logic [SUM_W:0]    b_wide, p_wide;
   logic [BASE_W-1:0] b_sat;
   logic [PMAX_W-1:0] p_sat;
   logic [NUM_W:0]    q1;
   logic [VEL_W-1:0]  vel;
   logic [BASE_W-1:0] den_lt;

   assign s     = SAMPLE_WIDTH'(item_ff.sample);
   assign s_sq  = (2*SAMPLE_WIDTH)'(s) * (2*SAMPLE_WIDTH)'(s);
   assign n_eff = (count_ff == '0) ? CNT_W'(1) : count_ff;
   assign idx   = (item_ff.op == OP_FINISH) ? cmd.cal_idx : SIDX_W'(item_ff.sensor);

   assign sel_sum = cmd.cal_hard ? hard_sum_ff[idx] : open_sum_ff[idx];
   assign sel_sq  = cmd.cal_hard ? hard_sq_ff[idx]  : open_sq_ff[idx];

   assign base   = base_ff[idx];
   assign pmax   = pmax_ff[idx];
   assign pmax_x = BASE_W'(pmax);

   // hysteresis levels
   assign s_x       = RC_W'(s);
   assign press_lvl = RC_W'(base) + RC_W'(press_thr_ff);
   assign rel_lvl   = RC_W'(base) + RC_W'(rel_thr_ff);
   assign press_hit = !pressed_ff[idx] && (s_x >= press_lvl);
   assign rel_hit   = pressed_ff[idx] && (s_x <= rel_lvl);
   assign run_d     = s - SAMPLE_WIDTH'(base);

   // shared divider operands, left aligned
   always_comb begin
      unique case (cmd.div_sel)
         DIV_MEAN: begin
            div_dividend = {sel_sum, {(DIVD_W-SUM_W){1'b0}}};
            div_divisor  = DIVS_W'(n_eff);
            div_steps    = DIV_CNT_W'(SUM_W);
         end
         DIV_VEL: begin
            div_dividend = {num_ff, {(DIVD_W-NUM_W){1'b0}}};
            div_divisor  = DIVS_W'(pmax - PMAX_W'(base));
            div_steps    = DIV_CNT_W'(NUM_W);
         end
         default: begin
            div_dividend = diff_ff;
            div_divisor  = nn_ff;
            div_steps    = DIV_CNT_W'(DIVD_W);
         end
      endcase
   end

   assign div_start = cmd.div_start;

   pkdc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .busy     (div_busy),
      .quotient (div_q)
   );

   pkdc_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_start),
      .value (div_q[SQ_W-1:0]),
      .busy  (sqrt_busy),
      .root  (sd)
   );

   // calibration results
   assign mean   = div_q[SUM_W-1:0];
   assign b_wide = {1'b0, mean} + (SUM_W+1)'({sd, 1'b0});
   assign p_wide = {1'b0, mean} + (SUM_W+1)'(sd);
   assign b_sat  = (b_wide > BASE_SAT) ? BASE_SAT[BASE_W-1:0] : b_wide[BASE_W-1:0];
   assign p_sat  = (p_wide > PMAX_SAT) ? PMAX_SAT[PMAX_W-1:0] : p_wide[PMAX_W-1:0];

   // press velocity
   assign q1     = {1'b0, div_q[NUM_W-1:0]} + (NUM_W+1)'(1);
   assign den_lt = base - pmax_x;
   always_comb begin
      unique case (vmode_ff)
         VM_GT:   vel = (q1 > (NUM_W+1)'(VEL_MAX)) ? VEL_MAX : q1[VEL_W-1:0];
         VM_LT:   vel = ({{BASE_W{1'b0}}, num_ff} >= {{NUM_W{1'b0}}, den_lt}) ?
                        VEL_W'(0) : VEL_W'(1);
         default: vel = VEL_MAX;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_thr_ff <= RST_PRESS_THR;
         rel_thr_ff   <= RST_REL_THR;
         count_ff     <= RST_COUNT;
         pressed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SENSORS; i++) begin
            open_sum_ff[i] <= '0;
            hard_sum_ff[i] <= '0;
            open_sq_ff[i]  <= '0;
            hard_sq_ff[i]  <= '0;
            base_ff[i]     <= '0;
            pmax_ff[i]     <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_PRESS_THR: press_thr_ff <= THR_W'(csr_wdata);
               CSR_REL_THR:   rel_thr_ff   <= THR_W'(csr_wdata);
               CSR_COUNT:     count_ff     <= CNT_W'(csr_wdata);
               default: ;
            endcase
         end

         if (cmd.accum) begin
            if (item_ff.op == OP_OPEN) begin
               open_sum_ff[idx] <= open_sum_ff[idx] + SUM_W'(s);
               open_sq_ff[idx]  <= open_sq_ff[idx] + SQ_W'(s_sq);
            end else begin
               hard_sum_ff[idx] <= hard_sum_ff[idx] + SUM_W'(s);
               hard_sq_ff[idx]  <= hard_sq_ff[idx] + SQ_W'(s_sq);
            end
         end

         if (cmd.run_eval) begin
            if (press_hit) begin
               pressed_ff[idx] <= 1'b1;
            end else if (rel_hit) begin
               pressed_ff[idx] <= 1'b0;
            end
         end

         if (cmd.cal_write && cmd.cal_hard) begin
            base_ff[idx]     <= btmp_ff;
            pmax_ff[idx]     <= p_sat;
            open_sum_ff[idx] <= '0;
            hard_sum_ff[idx] <= '0;
            open_sq_ff[idx]  <= '0;
            hard_sq_ff[idx]  <= '0;
         end

         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_payload;
      end
      if (cmd.cal_init) begin
         fail_ff     <= 1'b0;
         fail_idx_ff <= '0;
      end
      if (cmd.run_eval) begin
         num_ff <= NUM_W'(run_d) * NUM_W'(VEL_GAIN);
         if (pmax_x > base) begin
            vmode_ff <= VM_GT;
         end else if (pmax_x < base) begin
            vmode_ff <= VM_LT;
         end else begin
            vmode_ff <= VM_EQ;
         end
      end
      if (cmd.cal_mul) begin
         prod_a_ff <= PROD_W'(n_eff) * PROD_W'(sel_sq);
         prod_b_ff <= PROD_W'(sel_sum) * PROD_W'(sel_sum);
         nn_ff     <= NN_W'(n_eff) * NN_W'(n_eff);
      end
      if (cmd.cal_diff) begin
         diff_ff <= (prod_a_ff > prod_b_ff) ? (prod_a_ff - prod_b_ff) : '0;
      end
      if (cmd.cal_write) begin
         if (!cmd.cal_hard) begin
            btmp_ff <= b_sat;
         end else if (!fail_ff && (btmp_ff >= BASE_W'(p_sat))) begin
            fail_ff     <= 1'b1;
            fail_idx_ff <= idx;
         end
      end
      if (cmd.set_res) begin
         unique case (cmd.res_sel)
            RES_PRESS: begin
               res_ff.event_res    <= EV_PRESS;
               res_ff.event_sensor <= item_ff.sensor;
               res_ff.velocity     <= vel;
            end
            RES_RELEASE: begin
               res_ff.event_res    <= EV_RELEASE;
               res_ff.event_sensor <= item_ff.sensor;
               res_ff.velocity     <= '0;
            end
            default: begin
               res_ff.event_res    <= fail_ff ? EV_CAL_FAIL : EV_CAL_OK;
               res_ff.event_sensor <= fail_ff ? SENSOR_W'(fail_idx_ff) : '0;
               res_ff.velocity     <= '0;
            end
         endcase
      end
      if (cmd.rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign status.op        = item_ff.op;
   assign status.sensor_ok = 32'(item_ff.sensor) < SENSORS;
   assign status.press_hit = press_hit;
   assign status.rel_hit   = rel_hit;
   assign status.vel_div   = (vmode_ff == VM_GT);
   assign status.div_busy  = div_busy;
   assign status.sqrt_busy = sqrt_busy;
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

[sv/pkdc_ctrl.sv]
// Sequencer of the key detector: decodes items and steps the datapath.
// Uses pkdc_pkg and the assertion macros header.
`default_nettype none
`include "pressure_key_detector_calibrated_unit_defines.svh"

module pkdc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  pkdc_pkg::dp_status_type  status,
   output pkdc_pkg::dp_cmd_type     cmd
);
   import pkdc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_VSEL, S_VWAIT, S_MUL, S_DIFF, S_VARDIV, S_VARWAIT,
      S_MEAN, S_MEANWAIT, S_WRITE, S_RESULT, S_OUT
   } state_type;

   state_type         state_ff;
   logic [SIDX_W-1:0] k_ff;
   logic              hard_ff;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd          = '0;
      cmd.cal_idx  = k_ff;
      cmd.cal_hard = hard_ff;
      unique case (state_ff)
         S_IDLE:   cmd.load_item = req_valid;
         S_DECODE: begin
            if (status.op == OP_FINISH) begin
               cmd.cal_init = 1'b1;
            end else if (status.sensor_ok) begin
               if (status.op == OP_RUN) begin
                  cmd.run_eval = 1'b1;
                  cmd.set_res  = !status.press_hit && status.rel_hit;
                  cmd.res_sel  = RES_RELEASE;
               end else begin
                  cmd.accum = 1'b1;
               end
            end
         end
         S_VSEL: begin
            cmd.div_start = status.vel_div;
            cmd.div_sel   = DIV_VEL;
         end
         S_VWAIT: begin
            cmd.set_res = !status.div_busy;
            cmd.res_sel = RES_PRESS;
         end
         S_MUL:  cmd.cal_mul  = 1'b1;
         S_DIFF: cmd.cal_diff = 1'b1;
         S_VARDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_VAR;
         end
         S_VARWAIT: ;
         S_MEAN: begin
            cmd.sqrt_start = 1'b1;
            cmd.div_start  = 1'b1;
            cmd.div_sel    = DIV_MEAN;
         end
         S_MEANWAIT: ;
         S_WRITE:  cmd.cal_write = 1'b1;
         S_RESULT: begin
            cmd.set_res = 1'b1;
            cmd.res_sel = RES_CAL;
         end
         S_OUT:    cmd.rsp_load = status.rsp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
         hard_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               if (status.op == OP_FINISH) begin
                  k_ff     <= '0;
                  hard_ff  <= 1'b0;
                  state_ff <= S_MUL;
               end else if (!status.sensor_ok || status.op != OP_RUN) begin
                  state_ff <= S_IDLE;
               end else if (status.press_hit) begin
                  state_ff <= S_VSEL;
               end else if (status.rel_hit) begin
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_VSEL:  state_ff <= S_VWAIT;
            S_VWAIT: begin
               if (!status.div_busy) begin
                  state_ff <= S_OUT;
               end
            end
            S_MUL:     state_ff <= S_DIFF;
            S_DIFF:    state_ff <= S_VARDIV;
            S_VARDIV:  state_ff <= S_VARWAIT;
            S_VARWAIT: begin
               if (!status.div_busy) begin
                  state_ff <= S_MEAN;
               end
            end
            S_MEAN:    state_ff <= S_MEANWAIT;
            S_MEANWAIT: begin
               if (!status.div_busy && !status.sqrt_busy) begin
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: begin
               if (!hard_ff) begin
                  hard_ff  <= 1'b1;
                  state_ff <= S_MUL;
               end else if (k_ff == SIDX_W'(SENSORS - 1)) begin
                  state_ff <= S_RESULT;
               end else begin
                  hard_ff  <= 1'b0;
                  k_ff     <= k_ff + SIDX_W'(1);
                  state_ff <= S_MUL;
               end
            end
            S_RESULT: state_ff <= S_OUT;
            S_OUT: begin
               if (status.rsp_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `PKDC_ASSERT_NEXT(a_accept_decodes, clock, reset, req_valid && !req_stall, state_ff == S_DECODE, "accepted item not decoded")
   `PKDC_ASSERT_SAME(a_div_idle, clock, reset, cmd.div_start, !status.div_busy, "divider restarted while busy")
   `PKDC_ASSERT_SAME(a_rsp_free, clock, reset, cmd.rsp_load, status.rsp_free, "result overwrote a pending item")

endmodule

`default_nettype wire

[sv/pressure_key_detector_calibrated_unit.sv]
// Pressure key detector with mean / standard-deviation calibration.
// Channels: req_* carries one item (op, sensor, sample) with valid/stall;
// rsp_* carries at most one event item per request with valid/stall;
// csr_* writes the press level (0), the release level (1) and the cal count (2).
// One item is worked at a time; req_stall is high while an item is in work.
// Open/hard samples and run samples with no change give no result. A release
// goes straight to the output; a press runs the bit-serial velocity divider when
// the maximum is above the baseline. Finish: per sensor and phase a multiply,
// a variance divide, then mean divide and square root in parallel.
// A result sits in an output register; the next item is accepted while it
// waits, and a new result is staged and held until that register frees.
// Reset (synchronous, active high) restores the thresholds, clears all
// pressed flags, baselines, maxima and calibration sums, and drops rsp_valid.
// Users must write configuration only while no item is in work; not enforced.
`default_nettype none

module pressure_key_detector_calibrated_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  pkdc_pkg::req_type                  req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output pkdc_pkg::rsp_type                  rsp_payload,
   input  logic                               csr_we,
   input  logic [pkdc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pkdc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pkdc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   pkdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pkdc_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking bench for pressure_key_detector_calibrated_unit.
// Needs pkdc_pkg and the block; drives directed rows, then calibrate/run phases,
// and checks every event item against a fixed expectation or an in-bench model.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import pkdc_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_payload;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pressure_key_detector_calibrated_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // detector image
   logic [THR_W-1:0] press_thr, rel_thr;
   logic [CNT_W-1:0] cal_n;
   bit               held [SENSORS];
   longint unsigned  base_lv [SENSORS], pmax_lv [SENSORS];
   longint unsigned  osum [SENSORS], osq [SENSORS], hsum [SENSORS], hsq [SENSORS];

   rsp_type pending_events [$];
   int      fails, items_sent, events_seen, finishes_sent;
   int      tx_idle_pct, rx_idle_pct, idle_cycles;

   function automatic longint unsigned isqrt64(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   task automatic sum_stats(input longint unsigned sum, input longint unsigned sq,
                            output longint unsigned m, output longint unsigned d);
      longint unsigned n, a, b2, v;
      n  = (cal_n == 0) ? 1 : cal_n;
      a  = n * sq;
      b2 = sum * sum;
      v  = (a > b2) ? (a - b2) / (n * n) : 0;
      m  = sum / n;
      d  = isqrt64(v);
   endtask

   task automatic detector_step(input req_type it, output bit hit, output rsp_type ev);
      longint unsigned m, d, b, p, s, num, v;
      int fail_at;
      hit = 0;
      ev  = '0;
      s   = it.sample;
      if (it.op == OP_FINISH) begin
         fail_at = -1;
         for (int k = 0; k < SENSORS; k++) begin
            sum_stats(osum[k], osq[k], m, d);
            b = m + 2 * d;
            if (b > (1 << BASE_W) - 1) b = (1 << BASE_W) - 1;
            sum_stats(hsum[k], hsq[k], m, d);
            p = m + d;
            if (p > (1 << PMAX_W) - 1) p = (1 << PMAX_W) - 1;
            base_lv[k] = b;
            pmax_lv[k] = p;
            if (fail_at < 0 && b >= p) fail_at = k;
            osum[k] = 0; osq[k] = 0; hsum[k] = 0; hsq[k] = 0;
         end
         hit = 1;
         ev.event_res    = (fail_at < 0) ? EV_CAL_OK : EV_CAL_FAIL;
         ev.event_sensor = (fail_at < 0) ? '0 : SENSOR_W'(fail_at);
         return;
      end
      if (it.sensor >= SENSORS) return;
      if (it.op == OP_OPEN) begin
         osum[it.sensor] = (osum[it.sensor] + s) & ((64'd1 << SUM_W) - 1);
         osq[it.sensor]  = (osq[it.sensor] + s * s) & ((64'd1 << SQ_W) - 1);
      end else if (it.op == OP_HARD) begin
         hsum[it.sensor] = (hsum[it.sensor] + s) & ((64'd1 << SUM_W) - 1);
         hsq[it.sensor]  = (hsq[it.sensor] + s * s) & ((64'd1 << SQ_W) - 1);
      end else begin
         b = base_lv[it.sensor];
         p = pmax_lv[it.sensor];
         if (!held[it.sensor] && s >= b + press_thr) begin
            num = (s - b) * VEL_GAIN;
            if (p > b) begin
               v = num / (p - b) + 1;
               if (v > 127) v = 127;
            end else if (p < b) begin
               v = (num / (b - p) >= 1) ? 0 : 1;
            end else begin
               v = 127;
            end
            held[it.sensor] = 1;
            hit = 1;
            ev.event_res    = EV_PRESS;
            ev.event_sensor = it.sensor;
            ev.velocity     = VEL_W'(v);
         end else if (held[it.sensor] && s <= b + rel_thr) begin
            held[it.sensor] = 0;
            hit = 1;
            ev.event_res    = EV_RELEASE;
            ev.event_sensor = it.sensor;
         end
      end
   endtask

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(negedge clock) rsp_stall = ($urandom_range(0, 99) < rx_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         events_seen++;
         if (pending_events.size() == 0) begin
            $error("event item with none expected: %p", rsp_payload);
            fails++;
         end else begin
            rsp_type w;
            w = pending_events.pop_front();
            if (rsp_payload.event_res !== w.event_res) begin
               $error("event_res expected %0d actual %0d", w.event_res, rsp_payload.event_res);
               fails++;
            end
            if (rsp_payload.event_sensor !== w.event_sensor) begin
               $error("event_sensor expected %0d actual %0d",
                      w.event_sensor, rsp_payload.event_sensor);
               fails++;
            end
            if (rsp_payload.velocity !== w.velocity) begin
               $error("velocity expected %0d actual %0d", w.velocity, rsp_payload.velocity);
               fails++;
            end
         end
      end
   end

   // no-progress watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d events still expected", pending_events.size());
            $display("status: fail");
            $finish;
         end
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input req_type it, input bit typed, input rsp_type want);
      bit      hit;
      rsp_type ev;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid   = 1;
      req_payload = it;
      do @(posedge clock); while (req_stall);
      detector_step(it, hit, ev);
      if (typed) pending_events.push_back(want);
      else if (hit) pending_events.push_back(ev);
      items_sent++;
      if (it.op == OP_FINISH) finishes_sent++;
      @(negedge clock);
   endtask

   task automatic send_plain(input logic [OP_W-1:0] op, input int sn, input int smp);
      req_type it;
      it.op     = op;
      it.sensor = SENSOR_W'(sn);
      it.sample = SAMPLE_FIELD_W'(smp);
      send_item(it, 0, '0);
   endtask

   task automatic drain_events();
      req_valid = 0;
      while (pending_events.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int data);
      csr_we    = 1;
      csr_index = idx;
      csr_wdata = CSR_DATA_W'(data);
      if (idx == CSR_PRESS_THR) press_thr = THR_W'(data);
      else if (idx == CSR_REL_THR) rel_thr = THR_W'(data);
      else if (idx == CSR_COUNT) cal_n = CNT_W'(data);
      @(negedge clock);
      csr_we = 0;
   endtask

   function automatic int pick_thr();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 4095;
         default: return $urandom_range(2, 160);
      endcase
   endfunction

   dir_row_type dir_rows [] = '{
      '{'{OP_RUN,    3'd0, 12'd0},    1'b0, '0},
      '{'{OP_RUN,    3'd0, 12'd4095}, 1'b1, '{EV_PRESS, 3'd0, 7'd127}},
      '{'{OP_RUN,    3'd0, 12'd4095}, 1'b0, '0},
      '{'{OP_RUN,    3'd0, 12'd0},    1'b1, '{EV_RELEASE, 3'd0, 7'd0}},
      '{'{OP_RUN,    3'd7, 12'd4095}, 1'b0, '0},
      '{'{OP_OPEN,   3'd5, 12'd4095}, 1'b0, '0},
      '{'{OP_HARD,   3'd6, 12'd4095}, 1'b0, '0},
      '{'{OP_FINISH, 3'd0, 12'd0},    1'b1, '{EV_CAL_FAIL, 3'd0, 7'd0}},
      '{'{OP_OPEN,   3'd0, 12'd0},    1'b0, '0},
      '{'{OP_OPEN,   3'd0, 12'd4095}, 1'b0, '0},
      '{'{OP_HARD,   3'd0, 12'd4095}, 1'b0, '0},
      '{'{OP_HARD,   3'd4, 12'd4095}, 1'b0, '0},
      '{'{OP_OPEN,   3'd4, 12'd7},    1'b0, '0},
      '{'{OP_FINISH, 3'd7, 12'd4095}, 1'b0, '0},
      '{'{OP_RUN,    3'd4, 12'd4095}, 1'b0, '0},
      '{'{OP_RUN,    3'd0, 12'd4095}, 1'b0, '0},
      '{'{OP_RUN,    3'd4, 12'd0},    1'b0, '0},
      '{'{OP_RUN,    3'd0, 12'd0},    1'b0, '0}
   };

   initial begin
      int lo [SENSORS], hi [SENSORS];
      int phase, per_sensor, runs;
      req_type it;
      reset = 1; req_valid = 0; req_payload = '0; rsp_stall = 0;
      csr_we = 0; csr_index = '0; csr_wdata = '0;
      fails = 0; items_sent = 0; events_seen = 0; finishes_sent = 0;
      tx_idle_pct = 23; rx_idle_pct = 53;
      press_thr = RST_PRESS_THR; rel_thr = RST_REL_THR; cal_n = RST_COUNT;
      for (int k = 0; k < SENSORS; k++) begin
         held[k] = 0; base_lv[k] = 0; pmax_lv[k] = 0;
         osum[k] = 0; osq[k] = 0; hsum[k] = 0; hsq[k] = 0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (dir_rows[r]) send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);

      phase = 0;
      while (items_sent < 1915) begin
         if (items_sent < 700) begin
            tx_idle_pct = 23; rx_idle_pct = 53;
         end else if (items_sent < 1350) begin
            tx_idle_pct = 53; rx_idle_pct = 23;
         end else begin
            tx_idle_pct = 0; rx_idle_pct = 0;
         end
         // hold the sender until every event is back, then reconfigure
         drain_events();
         case (phase)
            0: begin
               csr_write(CSR_PRESS_THR, 4095); csr_write(CSR_REL_THR, 4095);
               csr_write(CSR_COUNT, 1023);
            end
            1: begin
               csr_write(CSR_PRESS_THR, 0); csr_write(CSR_REL_THR, 0);
               csr_write(CSR_COUNT, 0);
            end
            default: begin
               csr_write(CSR_PRESS_THR, pick_thr());
               csr_write(CSR_REL_THR, pick_thr());
               case ($urandom_range(0, 9))
                  0: csr_write(CSR_COUNT, 0);
                  1: csr_write(CSR_COUNT, 1023);
                  2: csr_write(CSR_COUNT, 1);
                  default: csr_write(CSR_COUNT, $urandom_range(2, 6));
               endcase
            end
         endcase

         if (phase == 3) begin
            // long open run at full scale wraps the sum and square stores
            repeat (1030) send_plain(OP_OPEN, 0, 4095);
            send_plain(OP_FINISH, $urandom_range(0, 7), $urandom_range(0, 4095));
         end

         per_sensor = (cal_n >= 1 && cal_n <= 8) ? cal_n : $urandom_range(1, 6);
         if ($urandom_range(0, 5) == 0) per_sensor = $urandom_range(1, 8);
         for (int k = 0; k < SENSORS; k++) begin
            lo[k] = $urandom_range(0, 3000);
            hi[k] = lo[k] + $urandom_range(60, 1000);
            if (hi[k] > 4000) hi[k] = 4000;
         end
         for (int k = 0; k < SENSORS; k++)
            for (int j = 0; j < 2 * per_sensor; j++) begin
               if ($urandom_range(0, 9) == 0) begin
                  it.op     = OP_W'($urandom_range(0, 3));
                  it.sensor = SENSOR_W'($urandom_range(0, 7));
                  it.sample = SAMPLE_FIELD_W'($urandom_range(0, 4095));
                  if (it.op == OP_FINISH && $urandom_range(0, 1)) it.op = OP_RUN;
                  send_item(it, 0, '0);
               end else if (j < per_sensor) begin
                  send_plain(OP_OPEN, k, lo[k] + $urandom_range(0, 30));
               end else begin
                  send_plain(OP_HARD, k, hi[k] + $urandom_range(0, 90));
               end
            end
         send_plain(OP_FINISH, $urandom_range(0, 7), $urandom_range(0, 4095));

         runs = $urandom_range(20, 45);
         repeat (runs) begin
            int k;
            k = $urandom_range(0, 4);
            case ($urandom_range(0, 5))
               0: send_plain(OP_RUN, $urandom_range(0, 7), $urandom_range(0, 4095));
               1, 2: send_plain(OP_RUN, k, lo[k] + $urandom_range(0, 60));
               default: send_plain(OP_RUN, k, hi[k] + $urandom_range(0, 95) - 40);
            endcase
         end
         phase++;
      end

      drain_events();
      $display("ran %0d items over %0d phases, %0d calibration finishes, %0d events checked",
               items_sent, phase, finishes_sent, events_seen);
      $display("thresholds and sample count swept incl. 0 and full scale, %0d mismatches",
               fails);
      if (fails == 0 && pending_events.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
+incdir+sv
sv/pkdc_pkg.sv
sv/pkdc_div.sv
sv/pkdc_sqrt.sv
sv/pkdc_datapath.sv
sv/pkdc_ctrl.sv
sv/pressure_key_detector_calibrated_unit.sv
tb/testbench.sv
